// ===== sv/gpf_pkg.sv =====
package gpf_pkg;

  localparam int ENDPOINT_ENTRIES_DEF = 256;
  localparam int INTERFACE_COUNT_DEF  = 256;
  localparam int CONTRACT_ENTRIES_DEF = 256;
  localparam int ADDRESS_ENTRIES_DEF  = 256;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] NO_GROUP = 16'hFFFF;
  localparam logic [31:0] ACL_ANY  = 32'hFFFF_FFFF;
  localparam logic [8:0]  REF_MAX  = 9'd511;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  localparam logic [2:0] OP_PKT    = 3'd0;
  localparam logic [2:0] OP_EP_ADD = 3'd1;
  localparam logic [2:0] OP_EP_DEL = 3'd2;
  localparam logic [2:0] OP_CT_ADD = 3'd3;
  localparam logic [2:0] OP_CT_DEL = 3'd4;
  localparam logic [2:0] OP_NOP    = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  interface_req;
    logic        is_ipv6;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [15:0] group;
    logic [15:0] peer_group;
    logic [31:0] acl_number;
  } in_beat_t;

  typedef struct packed {
    logic        permit;
    logic [15:0] source_group;
    logic [15:0] dest_group;
    logic [31:0] acl_result;
    logic [1:0]  status;
    logic        interface_active;
  } out_beat_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  itf;
    logic        v6;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] grp;
    logic [15:0] peer;
    logic [31:0] acl;
  } work_t;

  typedef struct packed {
    logic        valid;
    logic        v6;
    logic [7:0]  itf;
    logic [15:0] grp;
    logic [63:0] hi;
    logic [63:0] lo;
  } ep_ent_t;

  typedef struct packed {
    logic        valid;
    logic        v6;
    logic [15:0] grp;
    logic [63:0] hi;
    logic [63:0] lo;
  } map_ent_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] acl;
  } ct_ent_t;

  typedef struct packed {
    logic [15:0] grp;
    logic [8:0]  refs;
  } itf_ent_t;

endpackage

// ===== sv/gpf_ram.sv =====
module gpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/gpf_front.sv =====
module gpf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gpf_pkg::in_beat_t in_data,
  output logic              q_valid,
  output gpf_pkg::work_t    q_head,
  input  logic              q_pop
);
  import gpf_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  work_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  work_t          cls;
  logic           push, pop;

  // classify: fold unused modes, normalize ipv4 addresses
  always_comb begin
    cls.op   = (in_data.mode > OP_NOP) ? OP_NOP : in_data.mode;
    cls.itf  = in_data.interface_req;
    cls.v6   = in_data.is_ipv6;
    cls.hi   = in_data.is_ipv6 ? in_data.address_high : 64'd0;
    cls.lo   = in_data.is_ipv6 ? in_data.address_low : {32'd0, in_data.address_low[31:0]};
    cls.grp  = in_data.group;
    cls.peer = in_data.peer_group;
    cls.acl  = in_data.acl_number;
  end

  assign in_ready = cnt_r != CW'(QUEUE_DEPTH);
  assign q_valid  = cnt_r != '0;
  assign q_head   = slot_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= cls;
    end
  end

endmodule

// ===== sv/gpf_back.sv =====
module gpf_back #(
  parameter int ENDPOINT_ENTRIES = gpf_pkg::ENDPOINT_ENTRIES_DEF,
  parameter int INTERFACE_COUNT  = gpf_pkg::INTERFACE_COUNT_DEF,
  parameter int CONTRACT_ENTRIES = gpf_pkg::CONTRACT_ENTRIES_DEF,
  parameter int ADDRESS_ENTRIES  = gpf_pkg::ADDRESS_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  gpf_pkg::work_t     q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output gpf_pkg::out_beat_t out_data
);
  import gpf_pkg::*;

  localparam int EAW = $clog2(ENDPOINT_ENTRIES);
  localparam int MAW = $clog2(ADDRESS_ENTRIES);
  localparam int CAW = $clog2(CONTRACT_ENTRIES);
  localparam int IAW = $clog2(INTERFACE_COUNT);
  localparam int IXT = IAW + 8;
  localparam int M1 = (ENDPOINT_ENTRIES > ADDRESS_ENTRIES) ? ENDPOINT_ENTRIES : ADDRESS_ENTRIES;
  localparam int M2 = (CONTRACT_ENTRIES > INTERFACE_COUNT) ? CONTRACT_ENTRIES : INTERFACE_COUNT;
  localparam int MAXD = (M1 > M2) ? M1 : M2;
  localparam int CW = $clog2(MAXD + 1);
  localparam int XW = $clog2(MAXD);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ITF  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [1:0] TB_EP  = 2'd0;
  localparam logic [1:0] TB_MAP = 2'd1;
  localparam logic [1:0] TB_CT  = 2'd2;

  logic [2:0]    state_r, state_nxt;
  work_t         cur_r, cur_nxt;
  logic [1:0]    tab_r, tab_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [XW-1:0] pidx_r, pidx_nxt;
  logic          hit_r, hit_nxt, free_r, free_nxt;
  logic [XW-1:0] hidx_r, hidx_nxt, fidx_r, fidx_nxt;
  logic [31:0]   cap_r, cap_nxt;
  logic [15:0]   ksrc_r, ksrc_nxt, kdst_r, kdst_nxt;
  logic          e_new_r, e_new_nxt;
  logic [XW-1:0] e_idx_r, e_idx_nxt;
  logic [15:0]   sgrp_r, sgrp_nxt, dgrp_r, dgrp_nxt;
  logic [8:0]    refs_r, refs_nxt;
  logic [31:0]   aclr_r, aclr_nxt;
  logic          permit_r, permit_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_beat_t     out_r, out_nxt;
  logic          out_load;

  logic          scan_go;
  logic [1:0]    scan_tab;
  logic [CW-1:0] tdepth;
  logic          issue, scan_end, match, empty;
  logic [31:0]   capv;

  logic [IXT-1:0] head_ext, cur_ext;
  logic           itf_ok;

  logic                      ep_we, map_we, ct_we, itf_we;
  logic [EAW-1:0]            ep_waddr;
  logic [MAW-1:0]            map_waddr;
  logic [CAW-1:0]            ct_waddr;
  logic [IAW-1:0]            itf_waddr, itf_raddr;
  ep_ent_t                   ep_wd, ep_rd;
  map_ent_t                  map_wd, map_rd;
  ct_ent_t                   ct_wd, ct_rd;
  itf_ent_t                  itf_wd, itf_rd;
  logic [$bits(ep_ent_t)-1:0]  ep_rbits;
  logic [$bits(map_ent_t)-1:0] map_rbits;
  logic [$bits(ct_ent_t)-1:0]  ct_rbits;
  logic [$bits(itf_ent_t)-1:0] itf_rbits;

  assign ep_rd  = ep_ent_t'(ep_rbits);
  assign map_rd = map_ent_t'(map_rbits);
  assign ct_rd  = ct_ent_t'(ct_rbits);
  assign itf_rd = itf_ent_t'(itf_rbits);

  assign head_ext  = {{IAW{1'b0}}, q_head.itf};
  assign cur_ext   = {{IAW{1'b0}}, cur_r.itf};
  assign itf_ok    = cur_ext < IXT'(INTERFACE_COUNT);
  assign itf_raddr = head_ext[IAW-1:0];

  gpf_ram #(.WIDTH($bits(ep_ent_t)), .DEPTH(ENDPOINT_ENTRIES)) u_ep_ram (
    .clk(clk), .we(ep_we), .waddr(ep_waddr), .wdata(ep_wd),
    .raddr(cnt_r[EAW-1:0]), .rdata(ep_rbits));

  gpf_ram #(.WIDTH($bits(map_ent_t)), .DEPTH(ADDRESS_ENTRIES)) u_map_ram (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wd),
    .raddr(cnt_r[MAW-1:0]), .rdata(map_rbits));

  gpf_ram #(.WIDTH($bits(ct_ent_t)), .DEPTH(CONTRACT_ENTRIES)) u_ct_ram (
    .clk(clk), .we(ct_we), .waddr(ct_waddr), .wdata(ct_wd),
    .raddr(cnt_r[CAW-1:0]), .rdata(ct_rbits));

  gpf_ram #(.WIDTH($bits(itf_ent_t)), .DEPTH(INTERFACE_COUNT)) u_itf_ram (
    .clk(clk), .we(itf_we), .waddr(itf_waddr), .wdata(itf_wd),
    .raddr(itf_raddr), .rdata(itf_rbits));

  // table scan compare
  always_comb begin
    match  = 1'b0;
    empty  = 1'b0;
    capv   = '0;
    tdepth = CW'(CONTRACT_ENTRIES);
    case (tab_r)
      TB_EP: begin
        tdepth = CW'(ENDPOINT_ENTRIES);
        match  = ep_rd.valid && ep_rd.itf == cur_r.itf && ep_rd.v6 == cur_r.v6 &&
                 ep_rd.hi == cur_r.hi && ep_rd.lo == cur_r.lo;
        empty  = !ep_rd.valid;
      end
      TB_MAP: begin
        tdepth = CW'(ADDRESS_ENTRIES);
        match  = map_rd.valid && map_rd.v6 == cur_r.v6 &&
                 map_rd.hi == cur_r.hi && map_rd.lo == cur_r.lo;
        empty  = !map_rd.valid;
        capv   = {16'd0, map_rd.grp};
      end
      default: begin
        match = ct_rd.valid && ct_rd.src == ksrc_r && ct_rd.dst == kdst_r;
        empty = !ct_rd.valid;
        capv  = ct_rd.acl;
      end
    endcase
    issue    = cnt_r < tdepth;
    scan_end = !issue && !pend_r;
  end

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    tab_nxt    = tab_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    pidx_nxt   = pidx_r;
    hit_nxt    = hit_r;
    free_nxt   = free_r;
    hidx_nxt   = hidx_r;
    fidx_nxt   = fidx_r;
    cap_nxt    = cap_r;
    ksrc_nxt   = ksrc_r;
    kdst_nxt   = kdst_r;
    e_new_nxt  = e_new_r;
    e_idx_nxt  = e_idx_r;
    sgrp_nxt   = sgrp_r;
    dgrp_nxt   = dgrp_r;
    refs_nxt   = refs_r;
    aclr_nxt   = aclr_r;
    permit_nxt = permit_r;
    status_nxt = status_r;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    scan_go    = 1'b0;
    scan_tab   = TB_EP;

    ep_we     = 1'b0;
    map_we    = 1'b0;
    ct_we     = 1'b0;
    itf_we    = 1'b0;
    ep_waddr  = e_idx_r[EAW-1:0];
    map_waddr = hit_r ? hidx_r[MAW-1:0] : fidx_r[MAW-1:0];
    ct_waddr  = hit_r ? hidx_r[CAW-1:0] : fidx_r[CAW-1:0];
    itf_waddr = cur_ext[IAW-1:0];
    ep_wd     = '0;
    map_wd    = '0;
    ct_wd     = '0;
    itf_wd    = '{grp: NO_GROUP, refs: 9'd0};

    unique case (state_r)
      S_CLR: begin
        ep_we     = cnt_r < CW'(ENDPOINT_ENTRIES);
        map_we    = cnt_r < CW'(ADDRESS_ENTRIES);
        ct_we     = cnt_r < CW'(CONTRACT_ENTRIES);
        itf_we    = cnt_r < CW'(INTERFACE_COUNT);
        ep_waddr  = cnt_r[EAW-1:0];
        map_waddr = cnt_r[MAW-1:0];
        ct_waddr  = cnt_r[CAW-1:0];
        itf_waddr = cnt_r[IAW-1:0];
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CW'(MAXD - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_head;
          state_nxt = S_ITF;
        end
      end
      S_ITF: begin
        sgrp_nxt   = itf_ok ? itf_rd.grp : NO_GROUP;
        refs_nxt   = itf_ok ? itf_rd.refs : 9'd0;
        permit_nxt = 1'b0;
        dgrp_nxt   = NO_GROUP;
        aclr_nxt   = ACL_ANY;
        status_nxt = ST_OK;
        ksrc_nxt   = cur_r.grp;
        kdst_nxt   = cur_r.peer;
        unique case (cur_r.op) inside
          OP_PKT: begin
            scan_go  = 1'b1;
            scan_tab = TB_MAP;
          end
          OP_EP_ADD, OP_EP_DEL: begin
            scan_go  = 1'b1;
            scan_tab = TB_EP;
          end
          OP_CT_ADD, OP_CT_DEL: begin
            scan_go  = 1'b1;
            scan_tab = TB_CT;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_SCAN: begin
        if (pend_r) begin
          if (match && !hit_r) begin
            hit_nxt  = 1'b1;
            hidx_nxt = pidx_r;
            cap_nxt  = capv;
          end
          if (empty && !free_r) begin
            free_nxt = 1'b1;
            fidx_nxt = pidx_r;
          end
        end
        if (issue) begin
          cnt_nxt  = cnt_r + 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = cnt_r[XW-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (scan_end) begin
          state_nxt = S_OUT;
          unique case (cur_r.op)
            OP_PKT: begin
              if (tab_r == TB_MAP) begin
                if (!hit_r) begin
                  permit_nxt = 1'b1;
                end else begin
                  dgrp_nxt = cap_r[15:0];
                  if (cap_r[15:0] == sgrp_r) begin
                    permit_nxt = 1'b1;
                  end else begin
                    ksrc_nxt = sgrp_r;
                    kdst_nxt = cap_r[15:0];
                    scan_go  = 1'b1;
                    scan_tab = TB_CT;
                  end
                end
              end else if (hit_r) begin
                aclr_nxt   = cap_r;
                permit_nxt = cap_r == ACL_ANY;
              end
            end
            OP_EP_ADD: begin
              if (tab_r == TB_EP) begin
                if (!hit_r && !free_r) begin
                  status_nxt = ST_FULL;
                end else begin
                  e_new_nxt = !hit_r;
                  e_idx_nxt = hit_r ? hidx_r : fidx_r;
                  scan_go   = 1'b1;
                  scan_tab  = TB_MAP;
                end
              end else if (!hit_r && !free_r) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_WR;
              end
            end
            OP_EP_DEL: begin
              if (tab_r == TB_EP) begin
                if (!hit_r) begin
                  status_nxt = ST_MISS;
                end else begin
                  e_idx_nxt = hidx_r;
                  scan_go   = 1'b1;
                  scan_tab  = TB_MAP;
                end
              end else begin
                state_nxt = S_WR;
              end
            end
            OP_CT_ADD: begin
              if (!hit_r && !free_r) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_WR;
              end
            end
            OP_CT_DEL: begin
              if (!hit_r) begin
                status_nxt = ST_MISS;
              end else begin
                state_nxt = S_WR;
              end
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_WR: begin
        state_nxt = S_OUT;
        unique case (cur_r.op)
          OP_EP_ADD: begin
            ep_we  = 1'b1;
            ep_wd  = '{valid: 1'b1, v6: cur_r.v6, itf: cur_r.itf, grp: cur_r.grp,
                       hi: cur_r.hi, lo: cur_r.lo};
            map_we = 1'b1;
            map_wd = '{valid: 1'b1, v6: cur_r.v6, grp: cur_r.grp, hi: cur_r.hi, lo: cur_r.lo};
            if (itf_ok) begin
              itf_we   = 1'b1;
              sgrp_nxt = cur_r.grp;
              refs_nxt = (e_new_r && refs_r < REF_MAX) ? refs_r + 9'd1 : refs_r;
              itf_wd   = '{grp: sgrp_nxt, refs: refs_nxt};
            end
          end
          OP_EP_DEL: begin
            ep_we     = 1'b1;
            map_we    = hit_r;
            map_waddr = hidx_r[MAW-1:0];
            if (itf_ok) begin
              itf_we   = 1'b1;
              sgrp_nxt = (refs_r == 9'd1) ? NO_GROUP : sgrp_r;
              refs_nxt = (refs_r != 9'd0) ? refs_r - 9'd1 : refs_r;
              itf_wd   = '{grp: sgrp_nxt, refs: refs_nxt};
            end
          end
          OP_CT_ADD: begin
            ct_we = 1'b1;
            ct_wd = '{valid: 1'b1, src: cur_r.grp, dst: cur_r.peer, acl: cur_r.acl};
          end
          OP_CT_DEL: begin
            ct_we    = 1'b1;
            ct_waddr = hidx_r[CAW-1:0];
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (scan_go) begin
      state_nxt = S_SCAN;
      tab_nxt   = scan_tab;
      cnt_nxt   = '0;
      pend_nxt  = 1'b0;
      hit_nxt   = 1'b0;
      free_nxt  = 1'b0;
    end

    out_nxt = out_r;
    if (out_load) begin
      out_nxt = '{permit: permit_r, source_group: sgrp_r, dest_group: dgrp_r,
                  acl_result: aclr_r, status: status_r,
                  interface_active: refs_r != 9'd0};
    end
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r    <= cur_nxt;
    tab_r    <= tab_nxt;
    pidx_r   <= pidx_nxt;
    hit_r    <= hit_nxt;
    free_r   <= free_nxt;
    hidx_r   <= hidx_nxt;
    fidx_r   <= fidx_nxt;
    cap_r    <= cap_nxt;
    ksrc_r   <= ksrc_nxt;
    kdst_r   <= kdst_nxt;
    e_new_r  <= e_new_nxt;
    e_idx_r  <= e_idx_nxt;
    sgrp_r   <= sgrp_nxt;
    dgrp_r   <= dgrp_nxt;
    refs_r   <= refs_nxt;
    aclr_r   <= aclr_nxt;
    permit_r <= permit_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !q_pop)
    else $error("queue popped during clearing pass");

  a_load_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> state_r == S_OUT)
    else $error("result loaded outside output state");

  a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result appeared without an item finishing");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == S_SCAN)
    else $error("scan read pending outside scan");

endmodule

// ===== sv/group_policy_packet_filter_unit.sv =====
// flow: a packet scans the address table, then the contract table when it maps to another group;
// endpoint add/delete scan the endpoint table, then the address table; contract ops scan the
// contract table; a write state follows each update scan unless nothing is written
// throughput: one item at a time, set by the one-entry-per-cycle scan of each table memory
// a two-beat input queue keeps accepting, until it is full, while the engine works or a result waits
// reset: synchronous, then a clearing pass over the deepest table's entries before the first item
module group_policy_packet_filter_unit #(
  parameter int ENDPOINT_ENTRIES = gpf_pkg::ENDPOINT_ENTRIES_DEF,
  parameter int INTERFACE_COUNT  = gpf_pkg::INTERFACE_COUNT_DEF,
  parameter int CONTRACT_ENTRIES = gpf_pkg::CONTRACT_ENTRIES_DEF,
  parameter int ADDRESS_ENTRIES  = gpf_pkg::ADDRESS_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gpf_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gpf_pkg::out_beat_t out_data
);
  import gpf_pkg::*;

  logic  q_valid, q_pop;
  work_t q_head;

  gpf_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop));

  gpf_back #(
    .ENDPOINT_ENTRIES(ENDPOINT_ENTRIES), .INTERFACE_COUNT(INTERFACE_COUNT),
    .CONTRACT_ENTRIES(CONTRACT_ENTRIES), .ADDRESS_ENTRIES(ADDRESS_ENTRIES)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));

endmodule

// ===== dv/tb_group_policy_packet_filter_unit.sv =====
module tb_group_policy_packet_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import gpf_pkg::*;

  localparam int EP_N  = ENDPOINT_ENTRIES_DEF;
  localparam int MAP_N = ADDRESS_ENTRIES_DEF;
  localparam int IF_N  = INTERFACE_COUNT_DEF;
  localparam int CT_N  = CONTRACT_ENTRIES_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;

  group_policy_packet_filter_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // filter state mirror
  bit          ep_ok [EP_N];
  bit          ep_v6 [EP_N];
  logic [7:0]  ep_itf [EP_N];
  logic [15:0] ep_grp [EP_N];
  logic [63:0] ep_hi [EP_N];
  logic [63:0] ep_lo [EP_N];
  bit          mp_ok [MAP_N];
  bit          mp_v6 [MAP_N];
  logic [15:0] mp_grp [MAP_N];
  logic [63:0] mp_hi [MAP_N];
  logic [63:0] mp_lo [MAP_N];
  logic [15:0] if_grp [IF_N];
  logic [8:0]  if_refs [IF_N];
  bit          ct_ok [CT_N];
  logic [15:0] ct_src [CT_N];
  logic [15:0] ct_dst [CT_N];
  logic [31:0] ct_acl [CT_N];

  in_beat_t  pending_beats[$];
  out_beat_t expected_verdicts[$];
  int errors = 0;
  int cyc = 0;

  function automatic int find_ep(logic [7:0] itf, bit v6, logic [63:0] hi, logic [63:0] lo);
    for (int i = 0; i < EP_N; i++)
      if (ep_ok[i] && ep_itf[i] == itf && ep_v6[i] == v6 && ep_hi[i] == hi && ep_lo[i] == lo)
        return i;
    return -1;
  endfunction

  function automatic int find_map(bit v6, logic [63:0] hi, logic [63:0] lo);
    for (int i = 0; i < MAP_N; i++)
      if (mp_ok[i] && mp_v6[i] == v6 && mp_hi[i] == hi && mp_lo[i] == lo)
        return i;
    return -1;
  endfunction

  function automatic int find_ct(logic [15:0] src, logic [15:0] dst);
    for (int i = 0; i < CT_N; i++)
      if (ct_ok[i] && ct_src[i] == src && ct_dst[i] == dst)
        return i;
    return -1;
  endfunction

  function automatic int free_ep();
    for (int i = 0; i < EP_N; i++)
      if (!ep_ok[i]) return i;
    return -1;
  endfunction

  function automatic int free_map();
    for (int i = 0; i < MAP_N; i++)
      if (!mp_ok[i]) return i;
    return -1;
  endfunction

  function automatic int free_ct();
    for (int i = 0; i < CT_N; i++)
      if (!ct_ok[i]) return i;
    return -1;
  endfunction

  function automatic out_beat_t classify_or_update(in_beat_t b);
    out_beat_t r;
    bit v6;
    logic [63:0] hi, lo;
    bit itf_ok;
    logic [15:0] sgrp;
    int e, m, c, ne, nm;
    v6 = b.is_ipv6;
    hi = v6 ? b.address_high : 64'd0;
    lo = v6 ? b.address_low : {32'd0, b.address_low[31:0]};
    itf_ok = int'(b.interface_req) < IF_N;
    r = '0;
    r.dest_group = NO_GROUP;
    r.acl_result = ACL_ANY;
    r.status = ST_OK;
    case (b.mode)
      OP_PKT: begin
        sgrp = itf_ok ? if_grp[b.interface_req] : NO_GROUP;
        m = find_map(v6, hi, lo);
        if (m < 0) begin
          r.permit = 1'b1;
        end else begin
          r.dest_group = mp_grp[m];
          if (r.dest_group == sgrp) begin
            r.permit = 1'b1;
          end else begin
            c = find_ct(sgrp, r.dest_group);
            if (c >= 0) begin
              r.acl_result = ct_acl[c];
              r.permit = (ct_acl[c] == ACL_ANY);
            end
          end
        end
      end
      OP_EP_ADD: begin
        ne = -1;
        nm = -1;
        e = find_ep(b.interface_req, v6, hi, lo);
        m = find_map(v6, hi, lo);
        if (e < 0) ne = free_ep();
        if (m < 0) nm = free_map();
        if ((e < 0 && ne < 0) || (m < 0 && nm < 0)) begin
          r.status = ST_FULL;
        end else begin
          if (e < 0) begin
            e = ne;
            ep_ok[e] = 1'b1;
            ep_v6[e] = v6;
            ep_itf[e] = b.interface_req;
            ep_hi[e] = hi;
            ep_lo[e] = lo;
            if (itf_ok && if_refs[b.interface_req] < REF_MAX)
              if_refs[b.interface_req]++;
          end
          ep_grp[e] = b.group;
          if (itf_ok) if_grp[b.interface_req] = b.group;
          if (m < 0) begin
            m = nm;
            mp_ok[m] = 1'b1;
            mp_v6[m] = v6;
            mp_hi[m] = hi;
            mp_lo[m] = lo;
          end
          mp_grp[m] = b.group;
        end
      end
      OP_EP_DEL: begin
        e = find_ep(b.interface_req, v6, hi, lo);
        if (e < 0) begin
          r.status = ST_MISS;
        end else begin
          ep_ok[e] = 1'b0;
          if (itf_ok) begin
            if (if_refs[b.interface_req] == 9'd1) if_grp[b.interface_req] = NO_GROUP;
            if (if_refs[b.interface_req] > 0) if_refs[b.interface_req]--;
          end
          m = find_map(v6, hi, lo);
          if (m >= 0) mp_ok[m] = 1'b0;
        end
      end
      OP_CT_ADD: begin
        c = find_ct(b.group, b.peer_group);
        if (c < 0) begin
          c = free_ct();
          if (c >= 0) begin
            ct_ok[c] = 1'b1;
            ct_src[c] = b.group;
            ct_dst[c] = b.peer_group;
          end
        end
        if (c < 0) r.status = ST_FULL;
        else ct_acl[c] = b.acl_number;
      end
      OP_CT_DEL: begin
        c = find_ct(b.group, b.peer_group);
        if (c < 0) r.status = ST_MISS;
        else ct_ok[c] = 1'b0;
      end
      default: ;
    endcase
    r.source_group = itf_ok ? if_grp[b.interface_req] : NO_GROUP;
    r.interface_active = itf_ok && if_refs[b.interface_req] != 0;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_beat_t mk(logic [2:0] op, logic [7:0] itf, bit v6, logic [63:0] hi,
                                  logic [63:0] lo, logic [15:0] grp, logic [15:0] peer,
                                  logic [31:0] acl);
    in_beat_t b;
    b.mode = op;
    b.interface_req = itf;
    b.is_ipv6 = v6;
    b.address_high = hi;
    b.address_low = lo;
    b.group = grp;
    b.peer_group = peer;
    b.acl_number = acl;
    return b;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    logic [63:0] a6h, a6l, a4, ph [16], pl [16], fh [EP_N + 1], fl [EP_N + 1];
    bit pv6 [16];
    logic [7:0] itfs [10];
    logic [15:0] grps [6], cs [CT_N + 1], cd [CT_N + 1];
    int k, sel;
    in_beat_t b;

    for (int i = 0; i < EP_N; i++) ep_ok[i] = 1'b0;
    for (int i = 0; i < MAP_N; i++) mp_ok[i] = 1'b0;
    for (int i = 0; i < CT_N; i++) ct_ok[i] = 1'b0;
    for (int i = 0; i < IF_N; i++) begin
      if_grp[i] = NO_GROUP;
      if_refs[i] = '0;
    end

    a6h = rand64();
    a6l = rand64();
    a4 = {32'hDEAD_BEEF, $urandom};
    // directed
    pending_beats.push_back(mk(OP_PKT, 8'd0, 1'b0, '1, '1, '1, '1, '1));
    pending_beats.push_back(mk(OP_EP_ADD, 8'd5, 1'b0, '1, a4, 16'd1, '0, '0));
    pending_beats.push_back(mk(OP_EP_ADD, 8'd5, 1'b0, '0, {~a4[63:32], a4[31:0]}, 16'd65534,
                               '1, '1));
    pending_beats.push_back(mk(OP_PKT, 8'd5, 1'b0, rand64(), a4, '0, '0, '0));
    pending_beats.push_back(mk(OP_EP_ADD, 8'd7, 1'b1, a6h, a6l, 16'd0, '0, '0));
    pending_beats.push_back(mk(OP_PKT, 8'd5, 1'b1, a6h, a6l, '0, '0, '0));
    pending_beats.push_back(mk(OP_CT_ADD, 8'd0, 1'b0, '0, '0, 16'd65534, 16'd0, 32'h1234_5678));
    pending_beats.push_back(mk(OP_PKT, 8'd5, 1'b1, a6h, a6l, '0, '0, '0));
    pending_beats.push_back(mk(OP_CT_ADD, 8'd0, 1'b0, '0, '0, 16'd65534, 16'd0, ACL_ANY));
    pending_beats.push_back(mk(OP_PKT, 8'd5, 1'b1, a6h, a6l, '0, '0, '0));
    pending_beats.push_back(mk(OP_CT_DEL, 8'd0, 1'b0, '0, '0, 16'd65534, 16'd0, '0));
    pending_beats.push_back(mk(OP_CT_DEL, 8'd0, 1'b0, '0, '0, 16'd65534, 16'd0, '0));
    pending_beats.push_back(mk(OP_EP_DEL, 8'd8, 1'b1, a6h, a6l, '0, '0, '0));
    pending_beats.push_back(mk(OP_EP_DEL, 8'd7, 1'b1, a6h, a6l, '0, '0, '0));
    pending_beats.push_back(mk(OP_PKT, 8'd255, 1'b1, a6h, a6l, '0, '0, '0));
    pending_beats.push_back(mk(OP_NOP, 8'd5, 1'b0, '0, a4, 16'd9, 16'd9, '0));
    pending_beats.push_back(mk(3'(OP_NOP + 1), 8'd5, 1'b1, '1, '1, '1, '1, '1));
    pending_beats.push_back(mk(3'(OP_NOP + 2), 8'd255, 1'b0, '0, '0, '0, '0, '0));
    pending_beats.push_back(mk(OP_EP_ADD, 8'd255, 1'b1, '1, '1, 16'd3, '0, '0));
    // shared address between two interfaces
    pending_beats.push_back(mk(OP_EP_ADD, 8'd9, 1'b0, '0, a4, 16'd3, '0, '0));
    pending_beats.push_back(mk(OP_EP_DEL, 8'd9, 1'b0, '0, a4, '0, '0, '0));
    pending_beats.push_back(mk(OP_PKT, 8'd9, 1'b0, '0, a4, '0, '0, '0));
    pending_beats.push_back(mk(OP_EP_DEL, 8'd5, 1'b0, '0, a4, '0, '0, '0));
    pending_beats.push_back(mk(OP_EP_DEL, 8'd255, 1'b1, '1, '1, '0, '0, '0));

    // fill endpoint and address tables, overflow, then send a delete for each address
    for (int i = 0; i <= EP_N; i++) begin
      fh[i] = rand64();
      fl[i] = {55'(rand64() >> 9), 9'(i)};
      pending_beats.push_back(mk(OP_EP_ADD, 8'($urandom), 1'b1, fh[i], fl[i],
                                 16'($urandom_range(65534)), '0, '0));
    end
    pending_beats.push_back(mk(OP_PKT, 8'($urandom), 1'b1, fh[3], fl[3], '0, '0, '0));
    for (int i = 0; i <= EP_N; i++) begin
      b = pending_beats[24 + i];
      pending_beats.push_back(mk(OP_EP_DEL, b.interface_req, 1'b1, fh[i], fl[i], '0, '0, '0));
    end

    // fill contract table, overflow, then drain
    for (int i = 0; i <= CT_N; i++) begin
      cs[i] = 16'($urandom_range(65534));
      cd[i] = 16'(i);
      pending_beats.push_back(mk(OP_CT_ADD, '0, 1'b0, '0, '0, cs[i], cd[i], $urandom));
    end
    for (int i = 0; i <= CT_N; i++)
      pending_beats.push_back(mk(OP_CT_DEL, '0, 1'b0, '0, '0, cs[i], cd[i], '0));

    // random traffic over small pools so lookups hit
    for (int i = 0; i < 16; i++) begin
      pv6[i] = $urandom_range(1);
      ph[i] = pv6[i] ? rand64() : '0;
      pl[i] = rand64();
    end
    for (int i = 0; i < 10; i++) itfs[i] = (i == 0) ? 8'd0 : (i == 1) ? 8'd255 : 8'($urandom);
    grps[0] = 16'd0;
    grps[1] = 16'd65534;
    for (int i = 2; i < 6; i++) grps[i] = 16'($urandom_range(65534));
    for (int i = 0; i < 40; i++) begin
      k = $urandom_range(15);
      sel = $urandom_range(99);
      b = mk(OP_PKT, itfs[$urandom_range(9)], pv6[k], ph[k], pl[k], grps[$urandom_range(5)],
             grps[$urandom_range(5)], ($urandom_range(2) == 0) ? ACL_ANY : $urandom);
      if (!pv6[k] && $urandom_range(1)) begin
        b.address_high = rand64();
        b.address_low[63:32] = $urandom;
      end
      if (sel < 35) b.mode = OP_PKT;
      else if (sel < 60) b.mode = OP_EP_ADD;
      else if (sel < 75) b.mode = OP_EP_DEL;
      else if (sel < 88) b.mode = OP_CT_ADD;
      else if (sel < 97) b.mode = OP_CT_DEL;
      else b.mode = 3'($urandom_range(7, 5));
      pending_beats.push_back(b);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_beats.size() == 0 && !in_valid && expected_verdicts.size() == 0);
    repeat (1200) @(posedge clk);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_verdicts.push_back(classify_or_update(in_data));
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 &&
            ((cyc % 100000) < 30000 || $urandom_range(99) >= 23)) begin
          in_valid <= 1'b1;
          in_data <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_beat_t exp_v;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %h", out_data);
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (out_data.permit !== exp_v.permit ||
              out_data.source_group !== exp_v.source_group ||
              out_data.dest_group !== exp_v.dest_group ||
              out_data.acl_result !== exp_v.acl_result ||
              out_data.status !== exp_v.status ||
              out_data.interface_active !== exp_v.interface_active) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp %0d %h %h %h %0d %0d got %0d %h %h %h %0d %0d",
                       exp_v.permit, exp_v.source_group, exp_v.dest_group, exp_v.acl_result,
                       exp_v.status, exp_v.interface_active, out_data.permit,
                       out_data.source_group, out_data.dest_group, out_data.acl_result,
                       out_data.status, out_data.interface_active);
          end
        end
      end
      out_ready <= ((cyc % 100000) >= 50000 && (cyc % 100000) < 80000) ||
                   $urandom_range(99) >= 23;
    end
  end

endmodule
